[src/bf2u8_pkg.sv]
// bf2u8_pkg: shared types and constants for the bfloat16 to uint8 converter.
// No dependencies.
`timescale 1ns / 1ps
package bf2u8_pkg;
  localparam int ValueW = 16;
  localparam int ModeW  = 3;
  localparam int OutW   = 8;

  localparam logic [ModeW-1:0] RM_RNE = 3'd0;
  localparam logic [ModeW-1:0] RM_RTZ = 3'd1;
  localparam logic [ModeW-1:0] RM_RDN = 3'd2;
  localparam logic [ModeW-1:0] RM_RUP = 3'd3;
  localparam logic [ModeW-1:0] RM_RMM = 3'd4;

  // Stage 1 result: decoded operand with shift amount.
  typedef struct packed {
    logic             nan;
    logic             big;
    logic             neg;
    logic [ModeW-1:0] mode;
    logic [7:0]       m;
    logic             lo;      // exponent below 134: right shift path
    logic             tiny;    // right shift above 10: sticky only
    logic [3:0]       sh;      // shift amount (left 0..7, right 1..10)
  } dec_t;

  // Stage 2 result: integer part with round and sticky bits.
  typedef struct packed {
    logic             nan;
    logic             big;
    logic             neg;
    logic [ModeW-1:0] mode;
    logic [15:0]      ipart;
    logic             rb;
    logic             st;
  } shf_t;

  typedef struct packed {
    logic [OutW-1:0] converted;
    logic            invalid_flag;
    logic            inexact_flag;
  } res_t;
endpackage

[src/bf2u8_stage.sv]
// bf2u8_stage: one pipeline register slot with valid bit and stall.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module bf2u8_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

  property p_hold;
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid && $stable(out_data);
  endproperty
  a_hold: assert property (p_hold) else $error("stage lost a stalled item");
  a_rdy: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("empty stage not ready");
  a_fill: assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> out_valid)
    else $error("accepted item missing");
endmodule

[src/bf2u8_round.sv]
// bf2u8_round: rounding increment, range check and flag generation.
// Depends on bf2u8_pkg.
`timescale 1ns / 1ps
module bf2u8_round (
  input  bf2u8_pkg::shf_t s,
  output bf2u8_pkg::res_t r
);
  import bf2u8_pkg::*;
  logic        inc;
  logic [16:0] mag;
  logic        inx;

  always_comb begin
    unique case (s.mode)
      RM_RNE:  inc = s.rb && (s.st || s.ipart[0]);
      RM_RDN:  inc = s.neg && (s.rb || s.st);
      RM_RUP:  inc = !s.neg && (s.rb || s.st);
      RM_RMM:  inc = s.rb;
      default: inc = 1'b0;
    endcase
    mag = {1'b0, s.ipart} + {16'd0, inc};
    inx = s.rb || s.st;
    r   = '0;
    if (s.nan) begin
      r.converted = 8'hFF; r.invalid_flag = 1'b1;
    end else if (!s.neg) begin
      if (s.big || mag > 17'd255) begin
        r.converted = 8'hFF; r.invalid_flag = 1'b1;
      end else begin
        r.converted = mag[7:0]; r.inexact_flag = inx;
      end
    end else if (s.big || mag != 17'd0) begin
      r.invalid_flag = 1'b1;
    end else begin
      r.inexact_flag = inx;
    end
  end
endmodule

[src/bf16_to_uint8_convert_top.sv]
// bf16_to_uint8_convert_top: bfloat16 to uint8 converter, three-stage pipeline.
// Depends on bf2u8_pkg, bf2u8_stage, bf2u8_round.
// Each request passes through the decode, shift and round registers (u_s1, u_s2, u_s3) in turn.
// Throughput: one request per cycle while the output is not stalled; stages are decode, shift, round.
// A stall at the output backs up stage by stage; nothing is dropped.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module bf16_to_uint8_convert_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // [15:0] value, [18:16] rounding_mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata   // [7:0] converted, [8] invalid, [9] inexact
);
  import bf2u8_pkg::*;

  localparam int DW = $bits(dec_t);
  localparam int SW = $bits(shf_t);

  logic [15:0] v;
  logic [7:0]  ex;
  dec_t d_in, d_q;
  shf_t s_in, s_q;
  res_t r_in, r_q;
  logic v1, r1, v2, r2;
  logic [4:0] er;
  logic [7:0] mask;

  // Decode: classify, rebuild mantissa, compute shift.
  always_comb begin
    v  = s_axis_tdata[15:0];
    ex = v[14:7];
    d_in.nan  = (ex == 8'hFF) && (v[6:0] != 7'd0);
    d_in.big  = ex >= 8'd142;
    d_in.neg  = v[15];
    d_in.mode = s_axis_tdata[18:16];
    d_in.m    = {ex != 8'd0, v[6:0]};
    d_in.lo   = ex < 8'd134;
    // effective exponent of a subnormal is that of ex = 1
    er = (ex == 8'd0) ? 5'd0 : ((ex >= 8'd123) ? 5'(ex - 8'd123) : 5'd0);
    d_in.tiny = ex < 8'd124;
    if (ex >= 8'd134) d_in.sh = 4'(ex - 8'd134);
    else              d_in.sh = 4'(5'd11 - er);
  end

  bf2u8_stage #(.W(DW)) u_s1 (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(d_in),
    .out_valid(v1), .out_ready(r1), .out_data(d_q));

  // Shift: integer part, round bit, sticky.
  always_comb begin
    s_in.nan = d_q.nan; s_in.big = d_q.big; s_in.neg = d_q.neg; s_in.mode = d_q.mode;
    s_in.ipart = '0; s_in.rb = 1'b0; s_in.st = 1'b0;
    mask = 8'hFF >> (4'd8 - ((d_q.sh > 4'd8) ? 4'd8 : d_q.sh));
    if (!d_q.lo) begin
      s_in.ipart = {8'd0, d_q.m} << d_q.sh;
    end else if (d_q.tiny) begin
      s_in.st = d_q.m != 8'd0;
    end else begin
      s_in.ipart = {8'd0, d_q.m >> d_q.sh};
      s_in.rb    = (d_q.sh <= 4'd8) ? d_q.m[3'(d_q.sh - 4'd1)] : 1'b0;
      // shift of 9 or 10: the whole mantissa lies below the round position
      s_in.st    = (d_q.sh > 4'd8) ? (d_q.m != 8'd0) : ((d_q.m & (mask >> 1)) != 8'd0);
    end
  end

  bf2u8_stage #(.W(SW)) u_s2 (
    .clk, .rst, .in_valid(v1), .in_ready(r1), .in_data(s_in),
    .out_valid(v2), .out_ready(r2), .out_data(s_q));

  bf2u8_round u_rnd (.s(s_q), .r(r_in));

  bf2u8_stage #(.W($bits(res_t))) u_s3 (
    .clk, .rst, .in_valid(v2), .in_ready(r2), .in_data(r_in),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(r_q));

  assign m_axis_tdata = {6'd0, r_q.inexact_flag, r_q.invalid_flag, r_q.converted};

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(r_q.invalid_flag && r_q.inexact_flag)) else $error("both flags set");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    v2 && s_q.nan |-> r_in.invalid_flag && r_in.converted == 8'hFF) else $error("nan result");
  a_neg: assert property (@(posedge clk) disable iff (rst)
    v2 && s_q.neg && !s_q.nan |-> r_in.converted == 8'd0) else $error("negative nonzero");
endmodule

[dv/bf16_to_uint8_convert_top_tb.sv]
// Testbench for bf16_to_uint8_convert_top: directed and random bfloat16 requests
// checked against a behavioral converter in a scoreboard class. Depends on bf2u8_pkg.
`timescale 1ns / 1ps
module bf16_to_uint8_convert_top_tb;
  import bf2u8_pkg::*;

  typedef struct packed {
    logic [7:0] converted;
    logic       invalid_flag;
    logic       inexact_flag;
  } conv_res_t;

  // Behavioral bfloat16 -> uint8 conversion
  function automatic conv_res_t convert_bf16(logic [15:0] v, logic [2:0] mode);
    conv_res_t  r;
    logic       neg, rb, st, big, inc;
    logic [7:0] ex, m;
    logic [6:0] fr;
    int unsigned ipart, sh, rem, mag;
    r = '0; rb = 0; st = 0; big = 0; ipart = 0;
    neg = v[15]; ex = v[14:7]; fr = v[6:0];
    m = (ex != 0) ? {1'b1, fr} : {1'b0, fr};
    if (ex == 8'hFF && fr != 0) begin
      r.converted = 8'hFF; r.invalid_flag = 1;
      return r;
    end
    if (ex >= 142) big = 1;
    else if (ex >= 134) ipart = m << (ex - 134);
    else begin
      // subnormals use the exponent of ex = 1
      sh = 134 - ((ex == 0) ? 1 : ex);
      if (sh > 10) st = (m != 0);
      else begin
        rem = m & ((1 << sh) - 1);
        ipart = m >> sh;
        rb = ((rem >> (sh - 1)) & 1) != 0;
        st = (rem & ((1 << (sh - 1)) - 1)) != 0;
      end
    end
    case (mode)
      RM_RNE:  inc = rb && (st || ipart[0]);
      RM_RDN:  inc = neg && (rb || st);
      RM_RUP:  inc = !neg && (rb || st);
      RM_RMM:  inc = rb;
      default: inc = 0;
    endcase
    mag = ipart + inc;
    if (!neg) begin
      if (big || mag > 255) begin r.converted = 8'hFF; r.invalid_flag = 1; end
      else begin r.converted = mag[7:0]; r.inexact_flag = rb || st; end
    end else begin
      if (big || mag != 0) r.invalid_flag = 1;
      else r.inexact_flag = rb || st;
    end
    return r;
  endfunction

  class conv_scoreboard;
    conv_res_t pending[$];
    int errors, checked;
    function void note_request(logic [15:0] v, logic [2:0] mode);
      pending.push_back(convert_bf16(v, mode));
    endfunction
    function void check_result(logic [15:0] d);
      conv_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (d[7:0] !== exp_r.converted) begin
        $display("%0t: converted exp %h got %h", $realtime, exp_r.converted, d[7:0]);
        errors++;
      end
      if (d[8] !== exp_r.invalid_flag) begin
        $display("%0t: invalid exp %b got %b", $realtime, exp_r.invalid_flag, d[8]);
        errors++;
      end
      if (d[9] !== exp_r.inexact_flag) begin
        $display("%0t: inexact exp %b got %b", $realtime, exp_r.inexact_flag, d[9]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        s_axis_tvalid = 0, m_axis_tready = 0;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tready, m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  conv_scoreboard sb = new();
  int          idle_cycles = 0;
  int          requests = 0;
  localparam int WatchdogLimit = 2000;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  bf16_to_uint8_convert_top u_top (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Monitor: sample at rising edge, count idle cycles for the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tdata[15:0], s_axis_tdata[18:16]);
        requests++;
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("bf16_to_uint8_convert_top verification failed");
        $finish;
      end
    end
  end

  // Output backpressure: ready stretches with stalls mixed in
  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic send_request(logic [15:0] v, logic [2:0] mode);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_axis_tdata  <= {5'b0, mode, v};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_value();
    logic [7:0] ex;
    case ($urandom_range(0, 4))
      0: ex = $urandom_range(0, 255);
      1: ex = $urandom_range(0, 2) == 0 ? 8'd0 : 8'd255;
      default: ex = $urandom_range(118, 143); // around the interesting range
    endcase
    return {$urandom_range(0, 1) == 1, ex, 7'($urandom_range(0, 127))};
  endfunction

  initial begin
    logic [15:0] dir_v[$];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // zero, minus zero, subnormal, minus subnormal, half, 1.5, 2.5, 255 (twice), 256,
    // +inf, -inf, NaN, -NaN, -0.5, -1, max finite, 2^15, 0.75, -0.75, 144
    dir_v = '{16'h0000, 16'h8000, 16'h0001, 16'h807F, 16'h3F00, 16'h3FC0,
              16'h4020, 16'h437F, 16'h437F, 16'h4380, 16'h7F80, 16'hFF80,
              16'h7FC1, 16'hFFFF, 16'hBF00, 16'hBF80, 16'h7F7F, 16'h4700,
              16'h3F40, 16'hBF40, 16'h4310};
    foreach (dir_v[i]) send_request(dir_v[i], 3'(i));
    for (int md = 0; md < 8; md++) begin
      send_request(16'h3FC0, 3'(md));
      send_request(16'hBEC0, 3'(md));
    end
    repeat (850) send_request(rand_value(), 3'($urandom_range(0, 7)));
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d conversion requests, all rounding modes incl. NaN/inf/subnormal;",
             requests);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) $display("bf16_to_uint8_convert_top verification clean");
    else $display("bf16_to_uint8_convert_top verification failed");
    $finish;
  end
endmodule
